FILE: src/status_led_ws2812_driver_assert.svh
// ----------------------------------------------------------------------------
// Status LED WS2812 driver assertion macros
// Concurrent assertion helpers, compiled out when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef STATUS_LED_WS2812_DRIVER_ASSERT_SVH
`define STATUS_LED_WS2812_DRIVER_ASSERT_SVH

`ifndef SYNTH
// Property that must hold at every edge outside reset.
`define SLD_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("sld assertion failed");
// Condition in one cycle implies a property in the next one.
`define SLD_ASSERT_NEXT(lbl, clk, rstn, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
    else $error("sld assertion failed");
`else
`define SLD_ASSERT(lbl, clk, rstn, prop)
`define SLD_ASSERT_NEXT(lbl, clk, rstn, pre, post)
`endif

`endif

FILE: src/sld_pkg.sv
// ----------------------------------------------------------------------------
// Status LED driver package
// Shared types, constants and helper functions for the WS2812 status driver.
// ----------------------------------------------------------------------------
package sld_pkg;

  localparam int FRAME_BITS = 24;
  localparam int BL_W       = $clog2(FRAME_BITS + 1);
  localparam int COLOR_W    = 24;
  localparam int BLINK_W    = 26;
  localparam int CNT_W      = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 26;
  localparam int QDEPTH     = 2;
  localparam int QPTR_W     = $clog2(QDEPTH);
  localparam int QCNT_W     = $clog2(QDEPTH + 1);

  localparam logic [BLINK_W-1:0] BLINK_MAX = {BLINK_W{1'b1}};

  typedef logic [FRAME_BITS-1:0] frame_t;
  typedef logic [COLOR_W-1:0]    color_t;

  typedef enum logic [1:0] {
    OP_TICK   = 2'd0,
    OP_STATUS = 2'd1,
    OP_BLINK  = 2'd2,
    OP_RSVD   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OFF        = 2'd0,
    ST_CONNECTING = 2'd1,
    ST_CONNECTED  = 2'd2,
    ST_ERROR      = 2'd3
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CONNECTING = 3'd0,
    CFG_CONNECTED  = 3'd1,
    CFG_ERROR      = 3'd2,
    CFG_CTRL_BLINK = 3'd3,
    CFG_BLINK_TCK  = 3'd4,
    CFG_SHORT_TCK  = 3'd5,
    CFG_LONG_TCK   = 3'd6,
    CFG_LATCH_TCK  = 3'd7
  } cfg_idx_e;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_HIGH  = 2'd1,
    PH_LOW   = 2'd2,
    PH_LATCH = 2'd3
  } wave_phase_e;

  typedef struct packed {
    color_t               connecting_color;
    color_t               connected_color;
    color_t               error_color;
    color_t               control_blink_color;
    logic [BLINK_W-1:0]   blink_ticks;
    logic [7:0]           short_ticks;
    logic [7:0]           long_ticks;
    logic [CNT_W-1:0]     latch_ticks;
  } cfg_t;

  // One classified item handed from the front to the serializer.
  typedef struct packed {
    logic   req;
    color_t color;
    logic   blink;
  } sld_cmd_t;

  function automatic color_t status_color(input cfg_t cfg, input status_e st);
    color_t c;
    unique case (st)
      ST_CONNECTING: c = cfg.connecting_color;
      ST_CONNECTED:  c = cfg.connected_color;
      ST_ERROR:      c = cfg.error_color;
      default:       c = '0;
    endcase
    return c;
  endfunction

  // Zero durations count as one tick.
  function automatic logic [CNT_W-1:0] at_least_one(input logic [CNT_W-1:0] v);
    return (v == '0) ? CNT_W'(1) : v;
  endfunction

endpackage

FILE: src/status_led_ws2812_driver.sv
// ----------------------------------------------------------------------------
// Status LED WS2812 driver
// Status and blink controller that serializes GRB frames for one pixel.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_ready_o) takes one item per waveform tick:
//   a plain tick, a status change or a blink request. Every accepted item
//   yields exactly one result on the output channel (out_valid_o/out_ready_i)
//   that gives the line level, frame busy flag and blink flag for that tick.
//   Each item is written into the queue, then its result into the output
//   register; throughput is one item per cycle while the receiver keeps up.
//   The front end runs the status and blink timer, a two-entry queue carries
//   classified items to the serializer, which owns the one-entry request slot
//   (latest request wins) and the bit waveform of each frame.
//   When the receiver stalls, the output register holds its result; the
//   queue keeps taking items until it has two waiting, then in_ready_o drops.
//   Reset clears status to off, ends any blink, idles the line and loads the
//   default colors and timings. Write configuration through cfg_we_i,
//   cfg_idx_i and cfg_wdata_i only while no transfer is in flight.
// ----------------------------------------------------------------------------
module status_led_ws2812_driver (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [sld_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [sld_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [1:0]                         opcode_i,
  input  logic [1:0]                         status_value_i,
  input  logic                               blink_kind_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic                               line_level_o,
  output logic                               frame_busy_o,
  output logic                               blink_active_o
);
  import sld_pkg::*;

  cfg_t     cfg_q;
  sld_cmd_t front_cmd, back_cmd;
  logic     front_valid, front_ready;
  logic     back_valid, back_ready;

  // Configuration registers; a write takes effect the cycle after it, no read-back.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.connecting_color    <= COLOR_W'(8453888);
      cfg_q.connected_color     <= COLOR_W'(16711680);
      cfg_q.error_color         <= COLOR_W'(65280);
      cfg_q.control_blink_color <= COLOR_W'(255);
      cfg_q.blink_ticks         <= BLINK_W'(1000000);
      cfg_q.short_ticks         <= 8'd3;
      cfg_q.long_ticks          <= 8'd9;
      cfg_q.latch_ticks         <= CNT_W'(500);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_CONNECTING: cfg_q.connecting_color    <= cfg_wdata_i[COLOR_W-1:0];
        CFG_CONNECTED:  cfg_q.connected_color     <= cfg_wdata_i[COLOR_W-1:0];
        CFG_ERROR:      cfg_q.error_color         <= cfg_wdata_i[COLOR_W-1:0];
        CFG_CTRL_BLINK: cfg_q.control_blink_color <= cfg_wdata_i[COLOR_W-1:0];
        CFG_BLINK_TCK:  cfg_q.blink_ticks         <= cfg_wdata_i[BLINK_W-1:0];
        CFG_SHORT_TCK:  cfg_q.short_ticks         <= cfg_wdata_i[7:0];
        CFG_LONG_TCK:   cfg_q.long_ticks          <= cfg_wdata_i[7:0];
        CFG_LATCH_TCK:  cfg_q.latch_ticks         <= cfg_wdata_i[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Front end: classify each item and advance the blink timer.
  sld_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .opcode_i       (opcode_i),
    .status_value_i (status_value_i),
    .blink_kind_i   (blink_kind_i),
    .cmd_valid_o    (front_valid),
    .cmd_ready_i    (front_ready),
    .cmd_o          (front_cmd)
  );

  // Decouple front and serializer so each side can stall on its own.
  sld_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (front_valid),
    .push_ready_o (front_ready),
    .push_data_i  (front_cmd),
    .pop_valid_o  (back_valid),
    .pop_ready_i  (back_ready),
    .pop_data_o   (back_cmd)
  );

  // Serializer: one waveform tick per item, result held in an output register.
  sld_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .cmd_valid_i    (back_valid),
    .cmd_ready_o    (back_ready),
    .cmd_i          (back_cmd),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .line_level_o   (line_level_o),
    .frame_busy_o   (frame_busy_o),
    .blink_active_o (blink_active_o)
  );

endmodule

FILE: src/sld_front.sv
// ----------------------------------------------------------------------------
// Status LED driver front end
// Accept items, apply status and blink commands, run the blink timer.
// ----------------------------------------------------------------------------
module sld_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  sld_pkg::cfg_t    cfg_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [1:0]       opcode_i,
  input  logic [1:0]       status_value_i,
  input  logic             blink_kind_i,
  output logic             cmd_valid_o,
  input  logic             cmd_ready_i,
  output sld_pkg::sld_cmd_t cmd_o
);
  import sld_pkg::*;

  status_e             status_q, status_d;
  logic                blink_q, blink_d;
  logic [BLINK_W-1:0]  elapsed_q, elapsed_d;
  logic [BLINK_W-1:0]  elapsed_inc;
  logic                req;
  color_t              req_color;
  op_e                 op;
  logic                accept;

  assign op          = op_e'(opcode_i);
  assign in_ready_o  = cmd_ready_i;
  assign cmd_valid_o = in_valid_i;
  assign accept      = in_valid_i & cmd_ready_i;

  always_comb begin
    status_d    = status_q;
    blink_d     = blink_q;
    elapsed_d   = elapsed_q;
    req         = 1'b0;
    req_color   = '0;
    elapsed_inc = (elapsed_q != BLINK_MAX) ? elapsed_q + 1'b1 : elapsed_q;
    unique case (op)
      OP_STATUS: begin
        status_d = status_e'(status_value_i);
        if (!blink_q) begin
          req       = 1'b1;
          req_color = status_color(cfg_i, status_e'(status_value_i));
        end
      end
      OP_BLINK: begin
        blink_d   = 1'b1;
        elapsed_d = '0;
        req       = 1'b1;
        req_color = blink_kind_i ? cfg_i.connecting_color : cfg_i.control_blink_color;
      end
      default: ;
    endcase
    // Advance the blink timer; end the blink once it reaches its length.
    if (blink_q && (op != OP_BLINK)) begin
      elapsed_d = elapsed_inc;
      if (elapsed_inc >= cfg_i.blink_ticks) begin
        blink_d   = 1'b0;
        req       = 1'b1;
        req_color = status_color(cfg_i, status_d);
      end
    end
  end

  assign cmd_o.req   = req;
  assign cmd_o.color = req_color;
  assign cmd_o.blink = blink_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      status_q  <= ST_OFF;
      blink_q   <= 1'b0;
      elapsed_q <= '0;
    end else if (accept) begin
      status_q  <= status_d;
      blink_q   <= blink_d;
      elapsed_q <= elapsed_d;
    end
  end

endmodule

FILE: src/sld_queue.sv
// ----------------------------------------------------------------------------
// Status LED driver command queue
// Short FIFO between the front end and the serializer.
// ----------------------------------------------------------------------------
`include "status_led_ws2812_driver_assert.svh"

module sld_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_valid_i,
  output logic              push_ready_o,
  input  sld_pkg::sld_cmd_t push_data_i,
  output logic              pop_valid_o,
  input  logic              pop_ready_i,
  output sld_pkg::sld_cmd_t pop_data_o
);
  import sld_pkg::*;

  sld_cmd_t            mem_q [QDEPTH];
  logic [QPTR_W-1:0]   head_q, tail_q;
  logic [QCNT_W-1:0]   cnt_q;
  logic                push, pop;

  assign push_ready_o = (cnt_q != QCNT_W'(QDEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign push         = push_valid_i & push_ready_o;
  assign pop          = pop_valid_o & pop_ready_i;
  assign pop_data_o   = mem_q[head_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[tail_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      tail_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push) begin
        tail_q <= (tail_q == QPTR_W'(QDEPTH - 1)) ? '0 : tail_q + 1'b1;
      end
      if (pop) begin
        head_q <= (head_q == QPTR_W'(QDEPTH - 1)) ? '0 : head_q + 1'b1;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  `SLD_ASSERT(a_cnt_range, clk_i, rst_ni, cnt_q <= QCNT_W'(QDEPTH))
  `SLD_ASSERT_NEXT(a_cnt_up, clk_i, rst_ni, push && !pop, cnt_q == $past(cnt_q) + 1'b1)

endmodule

FILE: src/sld_back.sv
// ----------------------------------------------------------------------------
// Status LED driver serializer
// Hold the pending color slot, shape the WS2812 waveform, register results.
// ----------------------------------------------------------------------------
`include "status_led_ws2812_driver_assert.svh"

module sld_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  sld_pkg::cfg_t     cfg_i,
  input  logic              cmd_valid_i,
  output logic              cmd_ready_o,
  input  sld_pkg::sld_cmd_t cmd_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic              line_level_o,
  output logic              frame_busy_o,
  output logic              blink_active_o
);
  import sld_pkg::*;

  wave_phase_e        phase_q, phase_d, phase_eff;
  frame_t             shift_q, shift_d, shift_eff;
  logic [BL_W-1:0]    bl_q, bl_d, bl_eff, bl_dec;
  logic [CNT_W-1:0]   cnt_q, cnt_d, cnt_eff, cnt_dec;
  logic               pend_q, pend_d, pend_eff;
  color_t             pcol_q, pcol_d;
  logic               load, pop;
  logic [CNT_W-1:0]   short_len, long_len, latch_len;
  logic               level, busy;
  logic               out_valid_q, line_level_q, frame_busy_q, blink_active_q;

  assign short_len = at_least_one(CNT_W'(cfg_i.short_ticks));
  assign long_len  = at_least_one(CNT_W'(cfg_i.long_ticks));
  assign latch_len = at_least_one(cfg_i.latch_ticks);

  assign cmd_ready_o = !out_valid_q || out_ready_i;
  assign pop         = cmd_valid_i && cmd_ready_o;

  // Next state: pending slot, frame load, then one waveform tick.
  always_comb begin
    pend_eff  = pend_q | cmd_i.req;
    pcol_d    = cmd_i.req ? cmd_i.color : pcol_q;
    load      = (phase_q == PH_IDLE) && pend_eff;
    pend_d    = load ? 1'b0 : pend_eff;
    phase_eff = load ? PH_HIGH : phase_q;
    shift_eff = load ? frame_t'(pcol_d) : shift_q;
    bl_eff    = load ? BL_W'(FRAME_BITS) : bl_q;
    cnt_eff   = load ? (shift_eff[FRAME_BITS-1] ? long_len : short_len) : cnt_q;
    cnt_dec   = (cnt_eff != '0) ? cnt_eff - 1'b1 : cnt_eff;
    bl_dec    = (bl_eff != '0) ? bl_eff - 1'b1 : bl_eff;
    phase_d   = phase_eff;
    shift_d   = shift_eff;
    bl_d      = bl_eff;
    cnt_d     = cnt_dec;
    if (cnt_dec == '0) begin
      unique case (phase_eff)
        PH_HIGH: begin
          phase_d = PH_LOW;
          cnt_d   = shift_eff[FRAME_BITS-1] ? short_len : long_len;
        end
        PH_LOW: begin
          bl_d = bl_dec;
          if (bl_dec != '0) begin
            phase_d = PH_HIGH;
            shift_d = shift_eff << 1;
            cnt_d   = shift_eff[FRAME_BITS-2] ? long_len : short_len;
          end else begin
            phase_d = PH_LATCH;
            cnt_d   = latch_len;
          end
        end
        PH_LATCH: phase_d = PH_IDLE;
        default:  phase_d = PH_IDLE;
      endcase
    end
  end

  // Outputs of this tick.
  always_comb begin
    level = (phase_eff == PH_HIGH);
    busy  = (phase_eff != PH_IDLE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      shift_q <= '0;
      bl_q    <= '0;
      cnt_q   <= '0;
      pend_q  <= 1'b0;
      pcol_q  <= '0;
    end else if (pop) begin
      phase_q <= phase_d;
      shift_q <= shift_d;
      bl_q    <= bl_d;
      cnt_q   <= cnt_d;
      pend_q  <= pend_d;
      pcol_q  <= pcol_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_ready_o) begin
      out_valid_q <= cmd_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      line_level_q   <= level;
      frame_busy_q   <= busy;
      blink_active_q <= cmd_i.blink;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign line_level_o   = line_level_q;
  assign frame_busy_o   = frame_busy_q;
  assign blink_active_o = blink_active_q;

  `SLD_ASSERT(a_cnt_live, clk_i, rst_ni, (phase_q == PH_IDLE) || (cnt_q != '0))
  `SLD_ASSERT(a_bits_left, clk_i, rst_ni, (bl_q != '0) || (phase_q == PH_IDLE) || (phase_q == PH_LATCH))
  `SLD_ASSERT(a_idle_low, clk_i, rst_ni, !out_valid_q || frame_busy_q || !line_level_q)

endmodule
